>>> hw/rtl/wfu_pkg.sv
`timescale 1ns / 1ps

package wfu_pkg;

    // Length codes carried in the 7-bit length field
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Opcode of a close frame
    localparam logic [3:0] OPCODE_CLOSE = 4'd8;

    // Extended length byte counts, minus one
    localparam logic [2:0] EXT16_COUNT = 3'd1;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] MASK_COUNT  = 3'd3;

    // Parser phases, one-hot
    typedef enum logic [4:0] {
        PH_FIRST = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_EXT   = 5'b00100,
        PH_MASK  = 5'b01000,
        PH_DATA  = 5'b10000
    } wfu_phase_t;

    // Work item passed from the header parser to the unmask stage
    typedef struct packed {
        logic [7:0] byte_val;   // key byte or masked payload byte
        logic       is_key;     // mask key byte
        logic       key_last;   // final key byte of the header
        logic       is_data;    // payload byte
        logic       frame_last; // last result of the frame
        logic [3:0] opcode;
    } wfu_entry_t;

endpackage

>>> hw/rtl/wfu_front.sv
`timescale 1ns / 1ps

module wfu_front
    import wfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       entry_push,
    output wfu_entry_t entry
);

    wfu_phase_t  phase_reg, phase_next;
    logic [2:0]  count_reg, count_next;
    logic [63:0] remain_reg, remain_next;
    logic [3:0]  opcode_reg, opcode_next;

    // Header walk: one byte per transfer
    always_comb
    begin
        phase_next          = phase_reg;
        count_next          = count_reg;
        remain_next         = remain_reg;
        opcode_next         = opcode_reg;
        entry_push          = 1'b0;
        entry.byte_val      = in_byte;
        entry.is_key        = 1'b0;
        entry.key_last      = 1'b0;
        entry.is_data       = 1'b0;
        entry.frame_last    = 1'b0;
        entry.opcode        = opcode_reg;
        if (in_valid)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    if (in_byte[6:0] == LEN_EXT16)
                    begin
                        remain_next = '0;
                        count_next  = EXT16_COUNT;
                        phase_next  = PH_EXT;
                    end
                    else if (in_byte[6:0] == LEN_EXT64)
                    begin
                        remain_next = '0;
                        count_next  = EXT64_COUNT;
                        phase_next  = PH_EXT;
                    end
                    else
                    begin
                        remain_next = {57'd0, in_byte[6:0]};
                        count_next  = MASK_COUNT;
                        phase_next  = PH_MASK;
                    end
                end
                PH_EXT:
                begin
                    remain_next = {remain_reg[55:0], in_byte};
                    if (count_reg == 3'd0)
                    begin
                        count_next = MASK_COUNT;
                        phase_next = PH_MASK;
                    end
                    else
                    begin
                        count_next = count_reg - 3'd1;
                    end
                end
                PH_MASK:
                begin
                    entry_push   = 1'b1;
                    entry.is_key = 1'b1;
                    if (count_reg != 3'd0)
                    begin
                        count_next = count_reg - 3'd1;
                    end
                    else
                    begin
                        entry.key_last = 1'b1;
                        // zero-length frame closes on the last key byte
                        if (remain_reg == 64'd0)
                        begin
                            entry.frame_last = 1'b1;
                            phase_next       = PH_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    entry_push       = 1'b1;
                    entry.is_data    = 1'b1;
                    remain_next      = remain_reg - 64'd1;
                    entry.frame_last = (remain_reg == 64'd1);
                    if (remain_reg == 64'd1)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    opcode_next = in_byte[3:0];
                    count_next  = '0;
                    phase_next  = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            count_reg  <= '0;
            remain_reg <= '0;
            opcode_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            opcode_reg <= opcode_next;
        end
    end

endmodule

>>> hw/rtl/wfu_queue.sv
`timescale 1ns / 1ps

module wfu_queue
    import wfu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  wfu_entry_t wr_data,
    output logic       full,
    output logic       has_entry,
    input  logic       rd_en,
    output wfu_entry_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    wfu_entry_t    slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full      = (count_reg == FULL_COUNT);
    assign has_entry = (count_reg != '0);
    assign rd_data   = slots[rd_ptr_reg];
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && has_entry;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/wfu_back.sv
`timescale 1ns / 1ps

module wfu_back
    import wfu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       entry_valid,
    input  wfu_entry_t entry,
    output logic       entry_take,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] payload_byte,
    output logic       has_data,
    output logic       frame_last,
    output logic [3:0] frame_code,
    output logic       close_seen
);

    logic [31:0] key_reg, key_next;
    logic [1:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_reg, data_next;
    logic        has_reg, has_next;
    logic        last_reg, last_next;
    logic [3:0]  code_reg, code_next;
    logic        slot_free;
    logic        emit;
    logic [7:0]  key_byte;

    // Output slot frees up when empty or its result transfers this cycle
    assign slot_free  = !out_valid_reg || pop;
    assign entry_take = entry_valid && slot_free;
    assign emit       = entry.is_data || (entry.key_last && entry.frame_last);

    // Key byte for the current payload position, first key byte on top
    always_comb
    begin
        case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Unmask and result register
    always_comb
    begin
        key_next       = key_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !pop;
        data_next      = data_reg;
        has_next       = has_reg;
        last_next      = last_reg;
        code_next      = code_reg;
        if (entry_take)
        begin
            if (entry.is_key)
            begin
                key_next = {key_reg[23:0], entry.byte_val};
                if (entry.key_last)
                begin
                    pos_next = '0;
                end
            end
            else if (entry.is_data)
            begin
                pos_next = pos_reg + 2'd1;
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                data_next      = entry.is_data ? (entry.byte_val ^ key_byte) : 8'd0;
                has_next       = entry.is_data;
                last_next      = entry.frame_last;
                code_next      = entry.opcode;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        has_reg  <= has_next;
        last_reg <= last_next;
        code_reg <= code_next;
    end

    assign empty        = !out_valid_reg;
    assign payload_byte = data_reg;
    assign has_data     = has_reg;
    assign frame_last   = last_reg;
    assign frame_code   = code_reg;
    assign close_seen   = (code_reg == OPCODE_CLOSE);

endmodule

>>> hw/rtl/websocket_frame_unmasker.sv
`timescale 1ns / 1ps

// Client WebSocket frame unmasker. Frame bytes go in through push/full, one
// per transfer, header first; the block reads the opcode, the 7-, 16- or
// 64-bit length and the four mask-key bytes, then returns each payload byte
// XORed with its key byte on the result side (empty/pop), tagged with the
// opcode, a close flag and a last-of-frame marker. A zero-length frame gives
// one result with has_data low. FIN, RSV and MASK bits are not checked. The
// block sustains one byte per cycle while results are popped: the parser
// takes a byte every cycle while full is low; the unmask stage takes one
// queued byte per cycle while its result register is empty or popped. full
// rises only when the QUEUE_DEPTH-entry queue between parser and unmask
// stage fills, which happens only while the result side is not popping.

module websocket_frame_unmasker
    import wfu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] frame_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] payload_byte,
    output logic       has_data,
    output logic       frame_last,
    output logic [3:0] frame_code,
    output logic       close_seen
);

    wfu_entry_t front_entry;
    wfu_entry_t back_entry;
    logic       front_push;
    logic       q_has_entry;
    logic       back_take;
    logic       in_accept;

    assign in_accept = push && !full;

    // Header parser
    wfu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_accept),
        .in_byte    (frame_byte),
        .entry_push (front_push),
        .entry      (front_entry)
    );

    // Decoupling queue
    wfu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_push),
        .wr_data   (front_entry),
        .full      (full),
        .has_entry (q_has_entry),
        .rd_en     (back_take),
        .rd_data   (back_entry)
    );

    // Unmask stage and result register
    wfu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (q_has_entry),
        .entry        (back_entry),
        .entry_take   (back_take),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .has_data     (has_data),
        .frame_last   (frame_last),
        .frame_code   (frame_code),
        .close_seen   (close_seen)
    );

endmodule
